>>> hdl/rbs_pkg.sv
// Shared types and constants for the raised bevel shader.
package rbs_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COORD_W  = 16;
    localparam int BEVEL_W  = 15;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int NUM_W    = 26;
    localparam int QUO_W    = 17;
    localparam int RECIP_SH = 34;

    localparam logic [NUM_W-1:0] RECIP_510 = 26'd33686018;
    localparam logic [9:0]       DIV_510   = 10'd510;
    localparam logic [7:0]       C_STRONG  = 8'd190;
    localparam logic [7:0]       C_WEAK    = 8'd135;
    localparam logic [7:0]       C_FULL    = 8'd255;

    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_SIDE_WIDTH   = 3'd2;
    localparam logic [2:0] REG_BEVEL_HEIGHT = 3'd3;
    localparam logic [2:0] REG_RAISE_MODE   = 3'd4;

    localparam logic [COORD_W-1:0] RST_IMAGE_WIDTH  = 16'd640;
    localparam logic [COORD_W-1:0] RST_IMAGE_HEIGHT = 16'd480;
    localparam logic [BEVEL_W-1:0] RST_SIDE_WIDTH   = 15'd6;
    localparam logic [BEVEL_W-1:0] RST_BEVEL_HEIGHT = 15'd6;
    localparam logic               RST_RAISE_MODE   = 1'b1;

    typedef logic [SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        t_sample            red_in;
        t_sample            green_in;
        t_sample            blue_in;
    } t_pix_in;

    typedef struct packed {
        t_sample red_out;
        t_sample green_out;
        t_sample blue_out;
        logic    size_error;
    } t_pix_out;

    typedef struct packed {
        logic [COORD_W-1:0] image_width;
        logic [COORD_W-1:0] image_height;
        logic [BEVEL_W-1:0] side_width;
        logic [BEVEL_W-1:0] bevel_height;
        logic               raise_mode;
    } t_cfg;

    typedef struct packed {
        logic apply;
        logic heavy;
        logic pole_hi;
    } t_shade;

    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } t_stage_en;

endpackage

>>> hdl/rbs_if.sv
// Valid/ready stream interfaces for the shader's pixel channels.
interface rbs_in_if;
    import rbs_pkg::*;
    logic    valid;
    logic    ready;
    t_pix_in data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rbs_out_if;
    import rbs_pkg::*;
    logic     valid;
    logic     ready;
    t_pix_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hdl/rbs_cfg.sv
// APB register file holding the image and bevel geometry and the raise mode.
module rbs_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rbs_pkg::ADDR_W-1:0] paddr,
    input  logic [rbs_pkg::DATA_W-1:0] pwdata,
    output logic [rbs_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output rbs_pkg::t_cfg              o_cfg
);
    import rbs_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] w_idx;
    logic       w_wr;

    assign w_idx  = paddr[ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width  <= RST_IMAGE_WIDTH;
            r_cfg.image_height <= RST_IMAGE_HEIGHT;
            r_cfg.side_width   <= RST_SIDE_WIDTH;
            r_cfg.bevel_height <= RST_BEVEL_HEIGHT;
            r_cfg.raise_mode   <= RST_RAISE_MODE;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_IMAGE_WIDTH:  r_cfg.image_width  <= pwdata[COORD_W-1:0];
                REG_IMAGE_HEIGHT: r_cfg.image_height <= pwdata[COORD_W-1:0];
                REG_SIDE_WIDTH:   r_cfg.side_width   <= pwdata[BEVEL_W-1:0];
                REG_BEVEL_HEIGHT: r_cfg.bevel_height <= pwdata[BEVEL_W-1:0];
                REG_RAISE_MODE:   r_cfg.raise_mode   <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_IMAGE_WIDTH:  prdata = DATA_W'(r_cfg.image_width);
            REG_IMAGE_HEIGHT: prdata = DATA_W'(r_cfg.image_height);
            REG_SIDE_WIDTH:   prdata = DATA_W'(r_cfg.side_width);
            REG_BEVEL_HEIGHT: prdata = DATA_W'(r_cfg.bevel_height);
            REG_RAISE_MODE:   prdata = DATA_W'(r_cfg.raise_mode);
            default:          prdata = '0;
        endcase
    end
endmodule

>>> hdl/rbs_region.sv
// First pipeline stage: sample saturation and bevel region classification.
module rbs_region #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  rbs_pkg::t_cfg     i_cfg,
    input  rbs_pkg::t_pix_in  i_pix,
    output rbs_pkg::t_sample  o_red,
    output rbs_pkg::t_sample  o_green,
    output rbs_pkg::t_sample  o_blue,
    output rbs_pkg::t_shade   o_shade,
    output logic              o_err
);
    import rbs_pkg::*;

    localparam t_sample QMAX = SAMPLE_W'((17'(1) << SAMPLE_BITS) - 17'(1));

    t_sample r_red, r_green, r_blue;
    t_shade  r_shade;
    logic    r_err;
    t_shade  n_shade;
    logic    n_err;
    logic    w_fg_sel;

    logic signed [18:0] w_x, w_y, w_w, w_h, w_bw, w_bh, w_d;

    assign w_x  = signed'({3'b000, i_pix.column});
    assign w_y  = signed'({3'b000, i_pix.row});
    assign w_w  = signed'({3'b000, i_cfg.image_width});
    assign w_h  = signed'({3'b000, i_cfg.image_height});
    assign w_bw = signed'({4'b0000, i_cfg.side_width});
    assign w_bh = signed'({4'b0000, i_cfg.bevel_height});
    assign w_d  = w_h - w_y;

    function automatic t_sample clamp(input t_sample s);
        return (s > QMAX) ? QMAX : s;
    endfunction

    always_comb begin
        n_err = (i_cfg.image_width <= {i_cfg.side_width, 1'b0}) ||
                (i_cfg.image_height <= {i_cfg.bevel_height, 1'b0});
        n_shade.apply = 1'b0;
        n_shade.heavy = 1'b1;
        w_fg_sel      = 1'b1;
        if (!n_err && (w_x < w_w) && (w_y < w_h)) begin
            n_shade.apply = 1'b1;
            priority if (w_y < w_bh) begin
                priority if (w_x < w_y) begin
                    w_fg_sel = 1'b1;
                end else if (w_x < w_w - w_y) begin
                    n_shade.heavy = 1'b0;
                    w_fg_sel      = 1'b1;
                end else begin
                    w_fg_sel = 1'b0;
                end
            end else if (w_y < w_h - w_bh) begin
                priority if (w_x < w_bw) begin
                    w_fg_sel = 1'b1;
                end else if (w_x < w_w - w_bw) begin
                    n_shade.apply = 1'b0;
                end else begin
                    w_fg_sel = 1'b0;
                end
            end else begin
                priority if (w_x < w_d) begin
                    w_fg_sel = 1'b1;
                end else if (w_x < w_w - w_d) begin
                    n_shade.heavy = 1'b0;
                    w_fg_sel      = 1'b0;
                end else begin
                    w_fg_sel = 1'b0;
                end
            end
        end
        n_shade.pole_hi = ~(w_fg_sel ^ i_cfg.raise_mode);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_red   <= clamp(i_pix.red_in);
            r_green <= clamp(i_pix.green_in);
            r_blue  <= clamp(i_pix.blue_in);
            r_shade <= n_shade;
            r_err   <= n_err;
        end
    end

    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;
    assign o_shade = r_shade;
    assign o_err   = r_err;
endmodule

>>> hdl/rbs_blend.sv
// Three-stage blend of one channel toward its pole with rounded division by 255.
module rbs_blend #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                i_clk,
    input  rbs_pkg::t_stage_en  i_en,
    input  rbs_pkg::t_sample    i_px,
    input  rbs_pkg::t_shade     i_shade,
    output rbs_pkg::t_sample    o_px
);
    import rbs_pkg::*;

    localparam logic [NUM_W-1:0] QMAX =
        NUM_W'((27'(1) << SAMPLE_BITS) - 27'(1));
    localparam logic [NUM_W-1:0] POLE_STRONG = NUM_W'(QMAX * NUM_W'(C_FULL - C_STRONG));
    localparam logic [NUM_W-1:0] POLE_WEAK   = NUM_W'(QMAX * NUM_W'(C_FULL - C_WEAK));

    logic [NUM_W-1:0]   r_n2, r_n3;
    logic               r_apply2, r_apply3;
    t_sample            r_px2, r_px3, r_out4;
    logic [QUO_W-1:0]   r_q3;

    logic [NUM_W-1:0]   n_num;
    logic [2*NUM_W-1:0] w_prod;
    logic [NUM_W:0]     w_rem;
    logic [QUO_W-1:0]   n_q;

    always_comb begin
        n_num = NUM_W'(i_px) * NUM_W'(i_shade.heavy ? C_STRONG : C_WEAK);
        if (i_shade.pole_hi) begin
            n_num = n_num + (i_shade.heavy ? POLE_STRONG : POLE_WEAK);
        end
    end

    assign w_prod = (2*NUM_W)'(r_n2) * (2*NUM_W)'(RECIP_510);
    assign w_rem  = (NUM_W+1)'(r_n3) - (NUM_W+1)'(r_q3) * (NUM_W+1)'(DIV_510);
    assign n_q    = (w_rem >= (NUM_W+1)'(DIV_510)) ? r_q3 + QUO_W'(1) : r_q3;

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_n2     <= {n_num[NUM_W-2:0], 1'b0} + NUM_W'(C_FULL);
            r_apply2 <= i_shade.apply;
            r_px2    <= i_px;
        end
        if (i_en.s3) begin
            r_q3     <= w_prod[RECIP_SH +: QUO_W];
            r_n3     <= r_n2;
            r_apply3 <= r_apply2;
            r_px3    <= r_px2;
        end
        if (i_en.s4) begin
            r_out4 <= r_apply3 ? n_q[SAMPLE_W-1:0] : r_px3;
        end
    end

    assign o_px = r_out4;
endmodule

>>> hdl/raised_bevel_shader.sv
// Top level of the raised bevel shader: register port, region stage and blend lanes.
//
//  Port     Dir  Handshake      Carries
//  i_pix    in   valid/ready    column, row, red_in, green_in, blue_in
//  o_pix    out  valid/ready    red_out, green_out, blue_out, size_error
//  APB      in   psel/penable   image_width, image_height, side_width, bevel_height, raise_mode
//
// Each word passes from input to output through one register stage for the
// region decode and three for the multiply, reciprocal multiply and correction.
// A new word is taken every cycle while the output is drained.
// Reset is synchronous; it clears the stage valid bits and loads the configuration registers with their defaults.
// A stall holds each full stage; empty stages still fill, so bubbles collapse.
module raised_bevel_shader #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rbs_pkg::ADDR_W-1:0] paddr,
    input  logic [rbs_pkg::DATA_W-1:0] pwdata,
    output logic [rbs_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    rbs_in_if.sink                     i_pix,
    rbs_out_if.source                  o_pix
);
    import rbs_pkg::*;

    t_cfg      w_cfg;
    t_sample   w_red1, w_green1, w_blue1;
    t_sample   w_red4, w_green4, w_blue4;
    t_shade    w_shade1;
    logic      w_err1;
    logic      r_v1, r_v2, r_v3, r_v4;
    logic      r_err2, r_err3, r_err4;
    logic      w_rdy1, w_rdy2, w_rdy3, w_rdy4;
    t_stage_en w_en;

    assign w_rdy4 = !r_v4 || o_pix.ready;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign w_en   = '{s2: w_rdy2, s3: w_rdy3, s4: w_rdy4};

    assign i_pix.ready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_pix.valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2) r_err2 <= w_err1;
        if (w_rdy3) r_err3 <= r_err2;
        if (w_rdy4) r_err4 <= r_err3;
    end

    rbs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    rbs_region #(.SAMPLE_BITS(SAMPLE_BITS)) u_region (
        .i_clk   (i_clk),
        .i_en    (w_rdy1),
        .i_cfg   (w_cfg),
        .i_pix   (i_pix.data),
        .o_red   (w_red1),
        .o_green (w_green1),
        .o_blue  (w_blue1),
        .o_shade (w_shade1),
        .o_err   (w_err1)
    );

    rbs_blend #(.SAMPLE_BITS(SAMPLE_BITS)) u_blend_red (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_px    (w_red1),
        .i_shade (w_shade1),
        .o_px    (w_red4)
    );

    rbs_blend #(.SAMPLE_BITS(SAMPLE_BITS)) u_blend_green (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_px    (w_green1),
        .i_shade (w_shade1),
        .o_px    (w_green4)
    );

    rbs_blend #(.SAMPLE_BITS(SAMPLE_BITS)) u_blend_blue (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_px    (w_blue1),
        .i_shade (w_shade1),
        .o_px    (w_blue4)
    );

    assign o_pix.data  = '{red_out: w_red4, green_out: w_green4, blue_out: w_blue4,
                           size_error: r_err4};
    assign o_pix.valid = r_v4;
endmodule
